// ===== rtl/greedy_word_wrapper_defines.svh =====
// Assertion macros used by the word wrapper RTL.
`ifndef GREEDY_WORD_WRAPPER_DEFINES_SVH
`define GREEDY_WORD_WRAPPER_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every rising clock edge outside reset.
`define GWW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define GWW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define GWW_ASSERT(lbl, clk, rst_n, prop, msg)
`define GWW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/gww_pkg.sv =====
package gww_pkg;

    // Special text bytes.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // A tab adds this many spaces to the word.
    localparam logic [2:0] TAB_FILL = 3'd7;

    // Line width after reset.
    localparam logic [7:0] LINE_WIDTH_RST = 8'd80;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TAB,
        S_CHECK,
        S_NL,
        S_WORD,
        S_SPACE
    } t_state;

endpackage

// ===== rtl/greedy_word_wrapper.sv =====
// Flow: an ordinary byte is stored in the word; a separator or end of text starts a flush:
// a tab first pushes its 7 spaces, then the room is checked, then one output beat per cycle
// goes out while the receiver takes them. The block takes one ordinary byte per cycle while
// idle; a flush sends its beats through one word store read port and takes no input meanwhile.
// Reset: synchronous active low; line width 80, room 80, empty word, no store clearing.
`include "greedy_word_wrapper_defines.svh"

module greedy_word_wrapper #(
    parameter int MAX_WORD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration
    input  logic       i_line_width_we,
    input  logic [7:0] i_line_width,
    // Input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_text,
    // Output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_word_truncated
);
    import gww_pkg::*;

    localparam int WL_W = $clog2(MAX_WORD + 1);
    localparam int AW   = $clog2(MAX_WORD);

    // Control and status registers.
    t_state            r_state, n_state;
    logic [7:0]        r_line_width;
    logic [7:0]        r_room, n_room;
    logic [WL_W-1:0]   r_word_len, n_word_len;
    logic              r_ovf, n_ovf;
    logic              r_eot, n_eot;
    logic [2:0]        r_tab_cnt, n_tab_cnt;
    logic [WL_W-1:0]   r_idx, n_idx;

    // Output register.
    logic              r_o_valid;
    logic [7:0]        r_o_char;
    logic              r_o_last;
    logic              r_o_trunc;

    // Word store and its ports.
    logic [7:0]        mem [MAX_WORD];
    logic [7:0]        r_rd_data;
    logic              push_en;
    logic [7:0]        push_data;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    // Output load request.
    logic              out_free;
    logic              out_load;
    logic [7:0]        out_char;
    logic              out_last;

    // Room arithmetic.
    logic [8:0]        total;
    logic [8:0]        width_ext;
    logic              accept;
    logic              word_full;
    logic              last_byte;

    assign accept    = i_valid && o_ready;
    assign out_free  = !r_o_valid || i_ready;
    assign word_full = (r_word_len >= WL_W'(MAX_WORD));
    assign total     = 9'(r_word_len) + 9'd1;
    assign width_ext = {1'b0, r_line_width};
    assign last_byte = ((r_idx + WL_W'(1)) == r_word_len);
    assign wr_en     = push_en && !word_full;

    // Next state, pushes, reads and output loads.
    always_comb begin
        n_state    = r_state;
        n_room     = r_room;
        n_word_len = r_word_len;
        n_ovf      = r_ovf;
        n_eot      = r_eot;
        n_tab_cnt  = r_tab_cnt;
        n_idx      = r_idx;
        push_en    = 1'b0;
        push_data  = CH_SPACE;
        rd_en      = 1'b0;
        rd_addr    = '0;
        out_load   = 1'b0;
        out_char   = CH_SPACE;
        out_last   = 1'b0;
        o_ready    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (accept) begin
                    n_eot = i_end_of_text;
                    if (i_char_code == CH_TAB) begin
                        n_tab_cnt = TAB_FILL;
                        n_state   = S_TAB;
                    end else begin
                        if (i_char_code != CH_SPACE) begin
                            push_en   = 1'b1;
                            push_data = i_char_code;
                        end
                        if (i_char_code == CH_NL) begin
                            n_room = r_line_width;
                        end
                        if (i_end_of_text || i_char_code == CH_SPACE) begin
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_TAB: begin
                push_en   = 1'b1;
                push_data = CH_SPACE;
                n_tab_cnt = r_tab_cnt - 3'd1;
                if (r_tab_cnt == 3'd1) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_idx   = '0;
                if (r_eot && r_word_len == '0) begin
                    // Nothing to flush at end of text.
                    n_room  = r_line_width;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end else if (total > {1'b0, r_room}) begin
                    n_room  = (total > width_ext) ? 8'd0 : 8'(width_ext - total);
                    n_state = S_NL;
                end else begin
                    n_room  = 8'({1'b0, r_room} - total);
                    n_state = (r_word_len != '0) ? S_WORD : S_SPACE;
                end
            end
            S_NL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_char = CH_NL;
                    n_state  = (r_word_len != '0) ? S_WORD : S_SPACE;
                end
            end
            S_WORD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_char = r_rd_data;
                    out_last = last_byte && r_eot;
                    rd_en    = 1'b1;
                    rd_addr  = AW'(r_idx + WL_W'(1));
                    n_idx    = r_idx + WL_W'(1);
                    if (last_byte) begin
                        if (r_eot) begin
                            n_word_len = '0;
                            n_ovf      = 1'b0;
                            n_room     = r_line_width;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_SPACE;
                        end
                    end
                end
            end
            S_SPACE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_char   = CH_SPACE;
                    out_last   = 1'b1;
                    n_word_len = '0;
                    n_ovf      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A push into a full word drops the byte and marks the word.
        if (push_en) begin
            if (word_full) begin
                n_ovf = 1'b1;
            end else begin
                n_word_len = r_word_len + WL_W'(1);
            end
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
            r_room       <= LINE_WIDTH_RST;
            r_word_len   <= '0;
            r_ovf        <= 1'b0;
            r_eot        <= 1'b0;
            r_tab_cnt    <= '0;
            r_idx        <= '0;
        end else begin
            if (i_line_width_we) begin
                r_line_width <= i_line_width;
            end
            r_room     <= n_room;
            r_word_len <= n_word_len;
            r_ovf      <= n_ovf;
            r_eot      <= n_eot;
            r_tab_cnt  <= n_tab_cnt;
            r_idx      <= n_idx;
        end
    end

    // Word store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_word_len[AW-1:0]] <= push_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Output register: takes a new beat when empty or when the current one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_char  <= out_char;
            r_o_last  <= out_last;
            r_o_trunc <= r_ovf;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_out_char       = r_o_char;
    assign o_last_of_run    = r_o_last;
    assign o_word_truncated = r_o_trunc;

    // Checks on the sequencer and the output register.
    `GWW_ASSERT_NEVER(a_len_bound, i_clk, i_rst_n, r_word_len > WL_W'(MAX_WORD),
        "word length beyond the store depth")
    `GWW_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, out_load && r_o_valid && !i_ready,
        "output beat overwritten before it was taken")
    `GWW_ASSERT_NEVER(a_word_nonempty, i_clk, i_rst_n, r_state == S_WORD && r_word_len == '0,
        "word replay with an empty word")
    `GWW_ASSERT(a_eot_empty, i_clk, i_rst_n,
        (r_state == S_CHECK && r_eot && r_word_len == '0) |=>
            (r_state == S_IDLE && r_room == $past(r_line_width)),
        "empty end of text did not restart the line")

endmodule

// ===== test/testbench.sv =====
module testbench;
    import gww_pkg::*;

    localparam int WORD_CAP = 32;
    localparam int TAIL_CYCLES = 16;

    // One output beat of the wrapped stream.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } t_wrap_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_line_width_we = 1'b0;
    logic [7:0] i_line_width = 8'd0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_char_code = 8'd0;
    logic       i_end_of_text = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_char;
    logic       o_last_of_run;
    logic       o_word_truncated;

    // Wrapper state as the testbench sees it.
    logic [7:0] width_cfg = LINE_WIDTH_RST;
    logic [7:0] room = LINE_WIDTH_RST;
    logic [7:0] word_buf [WORD_CAP];
    int         word_len = 0;
    bit         word_ovf = 1'b0;

    t_wrap_beat beats_due[$];
    t_wrap_beat run_beats[$];
    int         mismatches = 0;
    int         chars_sent = 0;
    bit         idle_on = 1'b1;

    greedy_word_wrapper #(
        .MAX_WORD(WORD_CAP)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_line_width_we (i_line_width_we),
        .i_line_width    (i_line_width),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .i_end_of_text   (i_end_of_text),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_last_of_run   (o_last_of_run),
        .o_word_truncated(o_word_truncated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls now and then unless idling is switched off.
    always @(posedge i_clk) begin
        i_ready <= !idle_on || ($urandom_range(99) >= 6);
    end

    // Append one byte to the word, dropping it once the buffer is full.
    function automatic void store_byte(logic [7:0] c);
        if (word_len < WORD_CAP) begin
            word_buf[word_len] = c;
            word_len++;
        end else begin
            word_ovf = 1'b1;
        end
    endfunction

    // Send the word, preceded by a newline when it does not fit on the line.
    function automatic void flush_word(bit with_space);
        int total;
        int i;
        total = word_len + 1;
        if (total > room) begin
            run_beats.push_back('{CH_NL, 1'b0, word_ovf});
            room = (total > width_cfg) ? 8'd0 : 8'(width_cfg - total);
        end else begin
            room = 8'(room - total);
        end
        for (i = 0; i < word_len; i++) begin
            run_beats.push_back('{word_buf[i], 1'b0, word_ovf});
        end
        if (with_space) begin
            run_beats.push_back('{CH_SPACE, 1'b0, word_ovf});
        end
        word_len = 0;
        word_ovf = 1'b0;
    endfunction

    // Work out the beats that one accepted character causes.
    function automatic void wrap_char(logic [7:0] c, logic eot);
        bit         ends;
        int         i;
        t_wrap_beat beat;
        ends = (c == CH_SPACE) || (c == CH_TAB);
        run_beats.delete();
        if (c == CH_NL) begin
            room = width_cfg;
            store_byte(c);
        end else if (c == CH_TAB) begin
            for (i = 0; i < TAB_FILL; i++) begin
                store_byte(CH_SPACE);
            end
        end else if (c != CH_SPACE) begin
            store_byte(c);
        end
        if (eot) begin
            if (word_len > 0) begin
                flush_word(1'b0);
            end
            room = width_cfg;
            word_len = 0;
            word_ovf = 1'b0;
        end else if (ends) begin
            flush_word(1'b1);
        end
        foreach (run_beats[k]) begin
            beat = run_beats[k];
            beat.last = (k == run_beats.size() - 1);
            beats_due.push_back(beat);
        end
    endfunction

    // Compare every output beat with the oldest expected one.
    always @(posedge i_clk) begin
        t_wrap_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected beat: char %h last %b trunc %b",
                             o_out_char, o_last_of_run, o_word_truncated);
                end
            end else begin
                want = beats_due.pop_front();
                if (o_out_char !== want.ch || o_last_of_run !== want.last ||
                    o_word_truncated !== want.trunc) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("beat mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.ch, want.last, want.trunc,
                                 o_out_char, o_last_of_run, o_word_truncated);
                    end
                end
            end
        end
    end

    // Send one character beat, with an occasional gap before it.
    task automatic send_char(logic [7:0] c, logic eot);
        if (idle_on && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_ready);
        wrap_char(c, eot);
        chars_sent++;
    endtask

    // Hold the sender until every expected beat is out and the block is quiet.
    task automatic drain();
        i_valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Write the line width; only called while the block is idle.
    task automatic set_width(logic [7:0] w);
        i_line_width_we <= 1'b1;
        i_line_width <= w;
        @(posedge i_clk);
        i_line_width_we <= 1'b0;
        width_cfg = w;
    endtask

    // Random texts: words of random content split by separators, ended by end of text.
    // The text is closed early once the budget is spent.
    task automatic random_texts(int budget, int long_pct);
        int start;
        int n_words;
        int len;
        int w;
        int j;
        int pick;
        start = chars_sent;
        while (chars_sent - start < budget) begin
            n_words = $urandom_range(1, 8);
            for (w = 0; w < n_words && chars_sent - start < budget; w++) begin
                // A little noise: any byte, now and then marked end of text.
                if ($urandom_range(99) < 8) begin
                    send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
                end
                if ($urandom_range(99) < long_pct) begin
                    len = $urandom_range(25, 40);
                end else begin
                    len = $urandom_range(0, 10);
                end
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(99) < 85) begin
                        send_char(8'($urandom_range(33, 126)), 1'b0);
                    end else begin
                        send_char(8'($urandom_range(255)), 1'b0);
                    end
                end
                pick = $urandom_range(99);
                if (pick < 65) begin
                    send_char(CH_SPACE, 1'b0);
                end else if (pick < 85) begin
                    send_char(CH_TAB, 1'b0);
                end else begin
                    send_char(CH_NL, 1'b0);
                end
            end
            // Close the text on a byte, a separator or a newline.
            pick = $urandom_range(3);
            case (pick)
                0: begin
                    send_char(8'($urandom_range(33, 126)), 1'b1);
                end
                1: begin
                    send_char(CH_SPACE, 1'b1);
                end
                2: begin
                    send_char(CH_TAB, 1'b1);
                end
                default: begin
                    send_char(CH_NL, 1'b1);
                end
            endcase
        end
    endtask

    // Hand-picked characters covering each separator and corner of the wrapping.
    task automatic test_directed();
        // Plain word, then a word ended by a tab.
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char("c", 1'b0);
        send_char(CH_TAB, 1'b0);
        // Two separators in a row give a lone space.
        send_char(CH_SPACE, 1'b0);
        // An input newline stays in the word and restarts the room.
        send_char("d", 1'b0);
        send_char(CH_NL, 1'b0);
        send_char("e", 1'b0);
        send_char(CH_SPACE, 1'b0);
        // Extreme byte values, flushed by end of text.
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h7F, 1'b1);
        // End of text with an empty word sends nothing.
        send_char(CH_SPACE, 1'b1);
        // A tab at end of text keeps its spaces but no trailing space.
        send_char("f", 1'b0);
        send_char(CH_TAB, 1'b1);
        drain();
        // Narrow line: the word does not fit and the room saturates at zero.
        set_width(8'd3);
        send_char(CH_NL, 1'b0);
        send_char("x", 1'b0);
        send_char("y", 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char("z", 1'b1);
        drain();
        set_width(8'd255);
        send_char("w", 1'b0);
        send_char(CH_SPACE, 1'b1);
        drain();
    endtask

    // Random texts at the narrowest, widest and zero line widths.
    task automatic test_width_extremes();
        set_width(8'd1);
        random_texts(28, 5);
        drain();
        set_width(8'd255);
        random_texts(28, 5);
        drain();
        set_width(8'd0);
        random_texts(28, 5);
        drain();
    endtask

    // Mostly overlong words, so the buffer fills and the truncation flag shows.
    task automatic test_long_words();
        set_width(8'($urandom_range(10, 60)));
        random_texts(40, 60);
        drain();
    endtask

    // A stretch where neither side idles.
    task automatic test_no_idling();
        idle_on = 1'b0;
        set_width(LINE_WIDTH_RST);
        random_texts(30, 5);
        drain();
        idle_on = 1'b1;
    endtask

    // Random texts at random line widths.
    task automatic test_random_widths();
        int p;
        for (p = 0; p < 2; p++) begin
            set_width(8'($urandom_range(1, 255)));
            random_texts(28, 5);
            drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_width_extremes();
        test_long_words();
        test_no_idling();
        test_random_widths();
        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("** greedy_word_wrapper: PASSED **");
        end else begin
            $display("** greedy_word_wrapper: FAILED **");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #3000000;
        $display("** greedy_word_wrapper: FAILED **");
        $finish;
    end

endmodule
